/* design/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define SHRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shrt check failed");

// Implication with a fixed delay in cycles.
`define SHRT_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("shrt check failed");

`endif

/* design/shrt_pkg.sv */
// Types and constants for the session handover role tracker.
package shrt_pkg;

    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int GEN_W  = 32;
    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        KIND_SET_AUTH     = 3'd0,
        KIND_START_NEW    = 3'd1,
        KIND_CAND_READY   = 3'd2,
        KIND_CANCEL       = 3'd3,
        KIND_BEGIN_COMMIT = 3'd4,
        KIND_RETIRED      = 3'd5,
        KIND_DISCONNECT   = 3'd6,
        KIND_CAN_FORWARD  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ROLE_EMPTY    = 2'd0,
        ROLE_AUTH     = 2'd1,
        ROLE_PROV     = 2'd2,
        ROLE_RETIRING = 2'd3
    } role_t;

    // Classified event word passed from front to back.
    typedef struct packed {
        kind_t              kind;
        logic               slot_ok;
        logic [SLOT_W-1:0]  slot_idx;
        logic               ready_flag;
        logic               gen_nz;
        logic [GEN_W-1:0]   gen;
    } cmd_t;

endpackage

/* design/shrt_front.sv */
// Front end: accepts event words and classifies slot and generation.
module shrt_front
    import shrt_pkg::*;
(
    input  logic        start,
    input  logic        q_full,
    input  logic [2:0]  kind,
    input  logic [3:0]  slot,
    input  logic        ready_flag,
    input  logic [31:0] generation,
    output logic        busy,
    output logic        push,
    output cmd_t        cmd
);

    logic slot_in_range;

    assign slot_in_range = (slot < 4'(SLOTS));
    assign busy          = q_full;
    assign push          = start && !q_full;

    always_comb
    begin
        cmd.kind       = kind_t'(kind);
        cmd.slot_ok    = slot_in_range;
        cmd.slot_idx   = slot_in_range ? slot[SLOT_W-1:0] : '0;
        cmd.ready_flag = ready_flag;
        cmd.gen_nz     = |generation;
        cmd.gen        = generation;
    end

endmodule

/* design/shrt_queue.sv */
// Short shift queue of classified words between front and back.
module shrt_queue
    import shrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_cmd,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output cmd_t  head
);

    cmd_t              entry_reg [QDEPTH];
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entry 0 is the head; entries shift down on pop
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (do_pop)
            begin
                if (push && (QCNT_W'(i) == count_reg - 1'b1))
                begin
                    entry_reg[i] <= push_cmd;
                end
                else if (i < QDEPTH - 1)
                begin
                    entry_reg[i] <= entry_reg[(i + 1) % QDEPTH];
                end
            end
            else if (push && (QCNT_W'(i) == count_reg))
            begin
                entry_reg[i] <= push_cmd;
            end
        end
    end

endmodule

/* design/shrt_back.sv */
// Back end: applies one event word per cycle to the slot state.
module shrt_back
    import shrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        done,
    output logic        ok,
    output logic [3:0]  out_slot,
    output logic [31:0] out_generation
);

    role_t              role_reg  [SLOTS];
    role_t              role_next [SLOTS];
    logic [SLOTS-1:0]   ready_reg;
    logic [SLOTS-1:0]   ready_next;
    logic [SLOT_W-1:0]  auth_slot_reg, auth_slot_next;
    logic               auth_valid_reg, auth_valid_next;
    logic [SLOT_W-1:0]  prov_slot_reg, prov_slot_next;
    logic               prov_valid_reg, prov_valid_next;
    logic               new_active_reg, new_active_next;
    logic               commit_pending_reg, commit_pending_next;
    logic [GEN_W-1:0]   next_gen_reg, next_gen_next;
    logic [GEN_W-1:0]   active_gen_reg, active_gen_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [SLOT_W-1:0]  oslot_reg, oslot_next;
    logic [GEN_W-1:0]   ogen_reg, ogen_next;

    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic [GEN_W-1:0]   gen_inc;
    logic [SLOT_W-1:0]  s;
    logic               gen_match;

    assign s         = cmd.slot_idx;
    assign gen_match = cmd.gen_nz && (cmd.gen == active_gen_reg);
    assign gen_inc   = next_gen_reg + 1'b1;

    // lowest empty slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (role_reg[i] == ROLE_EMPTY)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            role_next[i] = role_reg[i];
        end
        ready_next          = ready_reg;
        auth_slot_next      = auth_slot_reg;
        auth_valid_next     = auth_valid_reg;
        prov_slot_next      = prov_slot_reg;
        prov_valid_next     = prov_valid_reg;
        new_active_next     = new_active_reg;
        commit_pending_next = commit_pending_reg;
        next_gen_next       = next_gen_reg;
        active_gen_next     = active_gen_reg;
        done_next           = cmd_valid;
        ok_next             = 1'b0;
        oslot_next          = '0;
        ogen_next           = '0;

        if (cmd_valid)
        begin
            case (cmd.kind)
                KIND_SET_AUTH:
                begin
                    if (cmd.slot_ok && !auth_valid_reg && role_reg[s] == ROLE_EMPTY)
                    begin
                        role_next[s]    = ROLE_AUTH;
                        ready_next[s]   = cmd.ready_flag;
                        auth_slot_next  = s;
                        auth_valid_next = 1'b1;
                        ok_next         = 1'b1;
                    end
                end
                KIND_START_NEW:
                begin
                    if (!new_active_reg && !commit_pending_reg && auth_valid_reg &&
                        ready_reg[auth_slot_reg] && free_found)
                    begin
                        next_gen_next         = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
                        active_gen_next       = next_gen_next;
                        new_active_next       = 1'b1;
                        prov_slot_next        = free_idx;
                        prov_valid_next       = 1'b1;
                        role_next[free_idx]   = ROLE_PROV;
                        ready_next[free_idx]  = 1'b0;
                        oslot_next            = free_idx;
                        ogen_next             = next_gen_next;
                        ok_next               = 1'b1;
                    end
                end
                KIND_CAND_READY:
                begin
                    if (cmd.slot_ok && new_active_reg && !commit_pending_reg &&
                        gen_match && prov_valid_reg && s == prov_slot_reg &&
                        role_reg[s] == ROLE_PROV)
                    begin
                        ready_next[s] = 1'b1;
                        ok_next       = 1'b1;
                    end
                end
                KIND_CANCEL:
                begin
                    if (gen_match && new_active_reg && !commit_pending_reg && prov_valid_reg)
                    begin
                        oslot_next                = prov_slot_reg;
                        role_next[prov_slot_reg]  = ROLE_EMPTY;
                        ready_next[prov_slot_reg] = 1'b0;
                        prov_valid_next           = 1'b0;
                        prov_slot_next            = '0;
                        new_active_next           = 1'b0;
                        active_gen_next           = '0;
                        ok_next                   = 1'b1;
                    end
                end
                KIND_BEGIN_COMMIT:
                begin
                    if (gen_match && new_active_reg && !commit_pending_reg &&
                        auth_valid_reg && prov_valid_reg && ready_reg[prov_slot_reg] &&
                        role_reg[auth_slot_reg] == ROLE_AUTH)
                    begin
                        oslot_next                = auth_slot_reg;
                        role_next[auth_slot_reg]  = ROLE_RETIRING;
                        ready_next[auth_slot_reg] = 1'b0;
                        auth_valid_next           = 1'b0;
                        auth_slot_next            = '0;
                        commit_pending_next       = 1'b1;
                        ok_next                   = 1'b1;
                    end
                end
                KIND_RETIRED:
                begin
                    if (cmd.slot_ok && gen_match && new_active_reg && commit_pending_reg &&
                        role_reg[s] == ROLE_RETIRING && prov_valid_reg &&
                        ready_reg[prov_slot_reg])
                    begin
                        role_next[s]             = ROLE_EMPTY;
                        ready_next[s]            = 1'b0;
                        oslot_next               = prov_slot_reg;
                        role_next[prov_slot_reg] = ROLE_AUTH;
                        auth_slot_next           = prov_slot_reg;
                        auth_valid_next          = 1'b1;
                        prov_valid_next          = 1'b0;
                        prov_slot_next           = '0;
                        new_active_next          = 1'b0;
                        commit_pending_next      = 1'b0;
                        active_gen_next          = '0;
                        ok_next                  = 1'b1;
                    end
                end
                KIND_DISCONNECT:
                begin
                    if (cmd.slot_ok && role_reg[s] != ROLE_EMPTY)
                    begin
                        role_next[s]  = ROLE_EMPTY;
                        ready_next[s] = 1'b0;
                        ok_next       = 1'b1;
                        if (role_reg[s] == ROLE_AUTH && auth_valid_reg && auth_slot_reg == s)
                        begin
                            auth_valid_next = 1'b0;
                            auth_slot_next  = '0;
                        end
                        if (role_reg[s] == ROLE_PROV)
                        begin
                            if (prov_valid_reg && prov_slot_reg == s)
                            begin
                                prov_valid_next = 1'b0;
                                prov_slot_next  = '0;
                            end
                            new_active_next = 1'b0;
                            active_gen_next = '0;
                        end
                    end
                end
                KIND_CAN_FORWARD:
                begin
                    ok_next = cmd.slot_ok && auth_valid_reg && auth_slot_reg == s &&
                              role_reg[s] == ROLE_AUTH && ready_reg[s];
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                role_reg[i] <= ROLE_EMPTY;
            end
            ready_reg          <= '0;
            auth_slot_reg      <= '0;
            auth_valid_reg     <= 1'b0;
            prov_slot_reg      <= '0;
            prov_valid_reg     <= 1'b0;
            new_active_reg     <= 1'b0;
            commit_pending_reg <= 1'b0;
            next_gen_reg       <= '0;
            active_gen_reg     <= '0;
            done_reg           <= 1'b0;
            ok_reg             <= 1'b0;
            oslot_reg          <= '0;
            ogen_reg           <= '0;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                role_reg[i] <= role_next[i];
            end
            ready_reg          <= ready_next;
            auth_slot_reg      <= auth_slot_next;
            auth_valid_reg     <= auth_valid_next;
            prov_slot_reg      <= prov_slot_next;
            prov_valid_reg     <= prov_valid_next;
            new_active_reg     <= new_active_next;
            commit_pending_reg <= commit_pending_next;
            next_gen_reg       <= next_gen_next;
            active_gen_reg     <= active_gen_next;
            done_reg           <= done_next;
            ok_reg             <= ok_next;
            oslot_reg          <= oslot_next;
            ogen_reg           <= ogen_next;
        end
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign out_slot       = 4'(oslot_reg);
    assign out_generation = ogen_reg;

endmodule

/* design/session_handover_role_tracker.sv */
// Session handover role tracker: top level.
//
// One event word is taken per cycle while busy is low. Its word is registered
// in the front queue, and the back end then registers the state update and the
// result, which is shown on done/ok/out_slot/out_generation. The back end retires
// one word every cycle, so the two-entry queue between front and back never holds
// more than one word and busy stays low: throughput is one event per cycle. The
// receiver cannot stall: each result is shown for a single cycle with done.
module session_handover_role_tracker
    import shrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [3:0]  slot,
    input  logic        ready_flag,
    input  logic [31:0] generation,
    output logic        done,
    output logic        ok,
    output logic [3:0]  out_slot,
    output logic [31:0] out_generation
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic q_full;
    logic q_not_empty;

    shrt_front u_front (
        .start      (start),
        .q_full     (q_full),
        .kind       (kind),
        .slot       (slot),
        .ready_flag (ready_flag),
        .generation (generation),
        .busy       (busy),
        .push       (push),
        .cmd        (front_cmd)
    );

    shrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (1'b1),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    shrt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_not_empty),
        .cmd            (head_cmd),
        .done           (done),
        .ok             (ok),
        .out_slot       (out_slot),
        .out_generation (out_generation)
    );

endmodule

/* design/shrt_checker.sv */
// Port-level checks for the session handover role tracker, with bind.
`include "assert_macros.svh"

module shrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [3:0]  out_slot,
    input logic [31:0] out_generation
);

    logic fail_word;
    logic payload_zero;

    assign fail_word    = done && !ok;
    assign payload_zero = (out_slot == 4'd0) && (out_generation == 32'd0);

    `SHRT_ASSERT_DELAY(a_word_result_latency, clk, rst_n, start && !busy, 2, done)
    `SHRT_ASSERT_SAME(a_fail_clears_payload, clk, rst_n, fail_word, payload_zero)
    `SHRT_ASSERT_SAME(a_gen_only_on_success, clk, rst_n, done && out_generation != 32'd0, ok)
    `SHRT_ASSERT_SAME(a_quiet_without_done, clk, rst_n, !done, !ok && payload_zero)

endmodule

bind session_handover_role_tracker shrt_checker u_shrt_checker (.*);
